>>> sv/sbid_pkg.sv
// ----------------------------------------------------------------------------
// sbid_pkg: shared types and constants for the stack bytecode decoder
// Phase codes, instruction kinds, variable reference classes, opcode numbers
// and the decoded record carried from the decoder to the result register.
// ----------------------------------------------------------------------------
package sbid_pkg;

  // Number of addressable variables; the reference byte is masked with it
  localparam int unsigned VarCount = 32;
  localparam logic [4:0]  VAR_IDX_MASK = 5'(VarCount - 1);

  // Opcodes with special operand handling
  localparam logic [6:0] OP_VAR_A   = 7'd0;
  localparam logic [6:0] OP_VAR_B   = 7'd5;
  localparam logic [6:0] OP_VAR_C   = 7'd6;
  localparam logic [6:0] OP_VAR_D   = 7'd32;
  localparam logic [6:0] OP_VAR_E   = 7'd37;
  localparam logic [6:0] OP_VAR_F   = 7'd38;
  localparam logic [6:0] OP_CALL    = 7'd64;
  localparam logic [6:0] OP_JUMP_A  = 7'd67;
  localparam logic [6:0] OP_JUMP_B  = 7'd68;

  // Extended push subcodes
  localparam logic [4:0] XP_ZERO    = 5'd0;
  localparam logic [4:0] XP_ONE     = 5'd1;
  localparam logic [4:0] XP_FONE    = 5'd2;
  localparam logic [4:0] XP_IMM8    = 5'd3;
  localparam logic [4:0] XP_IMM16   = 5'd4;
  localparam logic [4:0] XP_IMM32_A = 5'd5;
  localparam logic [4:0] XP_IMM32_B = 5'd6;
  localparam logic [4:0] XP_NONE    = 5'd7;
  localparam logic [4:0] XP_IMM32_C = 5'd8;
  localparam logic [4:0] XP_IMM32_D = 5'd9;

  localparam logic [31:0] FLOAT_ONE = 32'h3F80_0000;

  // Operand byte counts
  localparam logic [4:0] CALL_HDR_BYTES = 5'd16;
  localparam logic [4:0] CALL_WORD_LAST = 5'd12;  // header bytes kept while count above this

  typedef enum logic [2:0] {
    PH_OPCODE = 3'd0,
    PH_ARG    = 3'd1,
    PH_PROP   = 3'd2,
    PH_IMM    = 3'd3,
    PH_HDR    = 3'd4,
    PH_NAME   = 3'd5
  } phase_e;

  typedef enum logic [3:0] {
    KIND_PLAIN     = 4'd0,
    KIND_VAR_OP    = 4'd1,
    KIND_JUMP      = 4'd2,
    KIND_CALL      = 4'd3,
    KIND_PUSH_INT  = 4'd4,
    KIND_PUSH_PROP = 4'd5,
    KIND_PUSH_FLT  = 4'd6,
    KIND_PUSH_CST  = 4'd7,
    KIND_INVALID   = 4'd8
  } kind_e;

  typedef enum logic [1:0] {
    VC_NONE  = 2'd0,
    VC_INT   = 2'd1,
    VC_PROP  = 2'd2,
    VC_FLOAT = 2'd3
  } varcls_e;

  // Decoded instruction record
  typedef struct packed {
    logic [15:0] start_offset;
    logic [3:0]  kind;
    logic [6:0]  code;
    logic [1:0]  var_class;
    logic [4:0]  var_num;
    logic [7:0]  prop_byte;
    logic [31:0] value;
    logic        arg_error;
    logic [7:0]  name_length;
    logic [7:0]  instr_length;
  } rec_t;

  // Class of a variable reference byte from its top three bits
  function automatic varcls_e ref_class(input logic [7:0] b);
    varcls_e c;
    case (b[7:5])
      3'b100:  c = VC_INT;
      3'b101:  c = VC_PROP;
      3'b110:  c = VC_FLOAT;
      default: c = VC_NONE;
    endcase
    return c;
  endfunction

endpackage

>>> sv/sbid_in_stage.sv
// ----------------------------------------------------------------------------
// sbid_in_stage: input request register
// Captures one code byte per accepted request and holds it until the decoder
// takes it; refills in the same cycle it is drained.
// ----------------------------------------------------------------------------
module sbid_in_stage import sbid_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  // Occupancy
  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

>>> sv/sbid_decoder.sv
// ----------------------------------------------------------------------------
// sbid_decoder: instruction boundary state machine
// Holds the decode state, consumes one byte per step and builds the record
// of the instruction that the byte completes.
// ----------------------------------------------------------------------------
module sbid_decoder import sbid_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  output logic        emit_o,
  output rec_t        rec_o
);

  phase_e      phase_q, phase_d;
  logic [4:0]  left_q, left_d;
  logic [31:0] acc_q, acc_d;
  logic [15:0] offset_q;
  logic [15:0] start_q, start_d;
  kind_e       kind_q, kind_d;
  logic [6:0]  code_q, code_d;
  logic [7:0]  var_q, var_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  name_q, name_d;

  logic [4:0]  left_dec;
  varcls_e     byte_cls;
  logic [4:0]  sub;

  // Record side fields
  logic        emit;
  varcls_e     r_cls;
  logic [7:0]  r_ref;
  logic [7:0]  r_prop;
  logic        r_err;

  assign left_dec = (left_q != 5'd0) ? left_q - 5'd1 : 5'd0;
  assign byte_cls = ref_class(byte_i);
  assign sub      = byte_i[4:0];

  // Next state
  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    acc_d   = acc_q;
    start_d = start_q;
    kind_d  = kind_q;
    code_d  = code_q;
    var_d   = var_q;
    len_d   = (len_q != 8'hFF) ? len_q + 8'd1 : len_q;
    name_d  = name_q;
    case (phase_q)
      PH_ARG: begin
        var_d   = byte_i;
        phase_d = (byte_cls == VC_PROP) ? PH_PROP : PH_OPCODE;
      end
      PH_PROP: begin
        phase_d = PH_OPCODE;
      end
      PH_IMM: begin
        acc_d   = {acc_q[23:0], byte_i};
        left_d  = left_dec;
        phase_d = (left_dec == 5'd0) ? PH_OPCODE : PH_IMM;
      end
      PH_HDR: begin
        if (left_q > CALL_WORD_LAST) begin
          acc_d = {acc_q[23:0], byte_i};
        end
        left_d  = left_dec;
        phase_d = (left_dec == 5'd0) ? PH_NAME : PH_HDR;
      end
      PH_NAME: begin
        if (byte_i == 8'd0) begin
          phase_d = PH_OPCODE;
        end else if (name_q != 8'hFF) begin
          name_d = name_q + 8'd1;
        end
      end
      default: begin
        // Opcode byte: a new instruction starts here
        phase_d = PH_OPCODE;
        start_d = offset_q;
        len_d   = 8'd1;
        name_d  = 8'd0;
        acc_d   = 32'd0;
        var_d   = 8'd0;
        left_d  = 5'd0;
        if (!byte_i[7]) begin
          code_d = byte_i[6:0];
          case (byte_i[6:0])
            OP_VAR_A, OP_VAR_B, OP_VAR_C, OP_VAR_D, OP_VAR_E, OP_VAR_F: begin
              kind_d  = KIND_VAR_OP;
              phase_d = PH_ARG;
            end
            OP_CALL: begin
              kind_d  = KIND_CALL;
              left_d  = CALL_HDR_BYTES;
              phase_d = PH_HDR;
            end
            OP_JUMP_A, OP_JUMP_B: begin
              kind_d  = KIND_JUMP;
              left_d  = 5'd2;
              phase_d = PH_IMM;
            end
            default: begin
              kind_d = KIND_PLAIN;
            end
          endcase
        end else begin
          code_d = 7'd0;
          case (byte_cls)
            VC_INT: begin
              kind_d = KIND_PUSH_INT;
            end
            VC_FLOAT: begin
              kind_d = KIND_PUSH_FLT;
            end
            VC_PROP: begin
              kind_d  = KIND_PUSH_PROP;
              var_d   = byte_i;
              phase_d = PH_PROP;
            end
            default: begin
              // Extended push
              code_d = {2'b00, sub};
              kind_d = KIND_PUSH_CST;
              case (sub)
                XP_ZERO, XP_NONE: begin
                end
                XP_ONE: begin
                  acc_d = 32'd1;
                end
                XP_FONE: begin
                  acc_d = FLOAT_ONE;
                end
                XP_IMM8: begin
                  left_d  = 5'd1;
                  phase_d = PH_IMM;
                end
                XP_IMM16: begin
                  left_d  = 5'd2;
                  phase_d = PH_IMM;
                end
                XP_IMM32_A, XP_IMM32_B, XP_IMM32_C, XP_IMM32_D: begin
                  left_d  = 5'd4;
                  phase_d = PH_IMM;
                end
                default: begin
                  kind_d = KIND_INVALID;
                end
              endcase
            end
          endcase
        end
      end
    endcase
  end

  // Completion and variable fields of the record
  always_comb begin
    emit   = 1'b0;
    r_cls  = VC_NONE;
    r_ref  = 8'd0;
    r_prop = 8'd0;
    r_err  = 1'b0;
    case (phase_q)
      PH_ARG: begin
        if (byte_cls == VC_NONE) begin
          emit  = 1'b1;
          r_err = 1'b1;
        end else if (byte_cls != VC_PROP) begin
          emit  = 1'b1;
          r_cls = byte_cls;
          r_ref = byte_i;
        end
      end
      PH_PROP: begin
        emit   = 1'b1;
        r_cls  = VC_PROP;
        r_ref  = var_q;
        r_prop = byte_i;
      end
      PH_IMM: begin
        emit = (left_q <= 5'd1);
      end
      PH_HDR: begin
        emit = 1'b0;
      end
      PH_NAME: begin
        emit = (byte_i == 8'd0);
      end
      default: begin
        if (!byte_i[7]) begin
          emit = !(byte_i[6:0] inside {OP_VAR_A, OP_VAR_B, OP_VAR_C, OP_VAR_D, OP_VAR_E,
                                       OP_VAR_F, OP_CALL, OP_JUMP_A, OP_JUMP_B});
        end else if (byte_cls == VC_INT || byte_cls == VC_FLOAT) begin
          emit  = 1'b1;
          r_cls = byte_cls;
          r_ref = byte_i;
        end else if (byte_cls == VC_NONE) begin
          emit = !(sub inside {XP_IMM8, XP_IMM16, XP_IMM32_A, XP_IMM32_B,
                               XP_IMM32_C, XP_IMM32_D});
        end
      end
    endcase
  end

  // State registers; a config write reloads the offset counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_OPCODE;
      left_q   <= 5'd0;
      acc_q    <= 32'd0;
      offset_q <= 16'd0;
      start_q  <= 16'd0;
      kind_q   <= KIND_PLAIN;
      code_q   <= 7'd0;
      var_q    <= 8'd0;
      len_q    <= 8'd0;
      name_q   <= 8'd0;
    end else if (cfg_we_i) begin
      offset_q <= cfg_wdata_i;
    end else if (step_i) begin
      phase_q  <= phase_d;
      left_q   <= left_d;
      acc_q    <= acc_d;
      offset_q <= offset_q + 16'd1;
      start_q  <= start_d;
      kind_q   <= kind_d;
      code_q   <= code_d;
      var_q    <= var_d;
      len_q    <= len_d;
      name_q   <= name_d;
    end
  end

  assign emit_o = emit;

  // Record from the updated state
  always_comb begin
    rec_o.start_offset = start_d;
    rec_o.kind         = kind_d;
    rec_o.code         = code_d;
    rec_o.var_class    = r_cls;
    rec_o.var_num      = (r_cls != VC_NONE) ? (r_ref[4:0] & VAR_IDX_MASK) : 5'd0;
    rec_o.prop_byte    = r_prop;
    rec_o.value        = acc_d;
    rec_o.arg_error    = r_err;
    rec_o.name_length  = name_d;
    rec_o.instr_length = len_d;
  end

endmodule

>>> sv/sbid_out_stage.sv
// ----------------------------------------------------------------------------
// sbid_out_stage: result register
// Holds one decoded record until the receiver takes it.
// ----------------------------------------------------------------------------
module sbid_out_stage import sbid_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  rec_t rec_i,
  input  logic out_ready_i,
  output logic free_o,
  output logic out_valid_o,
  output rec_t rec_o
);

  logic valid_q, valid_d;
  rec_t rec_q;

  assign free_o = !valid_q || out_ready_i;

  // Occupancy
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rec_q <= rec_i;
    end
  end

  assign out_valid_o = valid_q;
  assign rec_o       = rec_q;

endmodule

>>> sv/stack_bytecode_instruction_decoder.sv
// ----------------------------------------------------------------------------
// stack_bytecode_instruction_decoder: bytecode instruction boundary decoder
// Feed code bytes on the input channel, one per request; each completed
// instruction comes out as one decoded record on the result channel.
//
// Input channel: in_valid_i/in_ready_o carry code_byte_i. Result channel:
// out_valid_o/out_ready_i carry the record fields. A byte that does not end
// an instruction produces no result.
// Path: an accepted byte waits in the input register until the result
// register is free; then it is decoded, and a completed record is loaded
// into the result register, which drives out_valid_o. Throughput: one byte
// per cycle while the result register is free; bytes stream back to back.
// Config: cfg_we_i loads cfg_wdata_i as the file offset of the next byte.
// Reset: decoder waits for an opcode, offset counter is zero, both
// registers are empty.
// Stall: while a record waits, the decoder holds; the input register keeps
// one byte and then deasserts in_ready_o.
// ----------------------------------------------------------------------------
module stack_bytecode_instruction_decoder import sbid_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  code_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] start_offset_o,
  output logic [3:0]  kind_o,
  output logic [6:0]  code_o,
  output logic [1:0]  var_class_o,
  output logic [4:0]  var_num_o,
  output logic [7:0]  prop_byte_o,
  output logic [31:0] value_o,
  output logic        arg_error_o,
  output logic [7:0]  name_length_o,
  output logic [7:0]  instr_length_o
);

  logic       byte_valid;
  logic [7:0] byte_val;
  logic       out_free;
  logic       step;
  logic       emit;
  rec_t       rec_dec;
  rec_t       rec_out;

  assign step = byte_valid && out_free;

  sbid_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .byte_i     (code_byte_i),
    .take_i     (step),
    .valid_o    (byte_valid),
    .byte_o     (byte_val)
  );

  sbid_decoder u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .byte_i      (byte_val),
    .emit_o      (emit),
    .rec_o       (rec_dec)
  );

  sbid_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && emit),
    .rec_i       (rec_dec),
    .out_ready_i (out_ready_i),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .rec_o       (rec_out)
  );

  assign start_offset_o = rec_out.start_offset;
  assign kind_o         = rec_out.kind;
  assign code_o         = rec_out.code;
  assign var_class_o    = rec_out.var_class;
  assign var_num_o      = rec_out.var_num;
  assign prop_byte_o    = rec_out.prop_byte;
  assign value_o        = rec_out.value;
  assign arg_error_o    = rec_out.arg_error;
  assign name_length_o  = rec_out.name_length;
  assign instr_length_o = rec_out.instr_length;

`ifndef NO_ASSERTIONS
  // Every instruction has at least its opcode byte
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> instr_length_o != 8'd0)
    else $error("record with zero instruction length");

  // Only calls carry a name length
  a_name_only_call: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != KIND_CALL) |-> name_length_o == 8'd0)
    else $error("name length on a non-call record");

  // A bad variable argument is a two-byte var-arg op without a reference
  a_arg_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && arg_error_o) |->
      (var_class_o == VC_NONE && instr_length_o == 8'd2 && kind_o == KIND_VAR_OP))
    else $error("inconsistent argument error record");

  // No reference means no index and no property
  a_no_ref: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && var_class_o == VC_NONE) |->
      (var_num_o == 5'd0 && prop_byte_o == 8'd0))
    else $error("variable fields set without a reference");

  // The decoder never consumes a byte while a record is stuck
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !step)
    else $error("decoder stepped while result register full");
`endif

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for stack_bytecode_instruction_decoder
// Streams code bytes into the decoder with random request gaps and result
// stalls, decodes the same stream in a local model, and compares every
// decoded record field by field. A fixed table of instructions runs first;
// then mostly well-formed instructions with random operands follow, mixed
// with stray bytes and cut-off sequences, over several start offsets.
// ----------------------------------------------------------------------------
module tb;
  import sbid_pkg::*;

  localparam int DRAIN_CYCLES = 4;     // two-stage pipe plus margin
  localparam int RAND_PER_PHASE = 170;
  localparam int DIR_N = 60;

  // Stimulus table row: code byte, and a typed-in record where one is obvious
  typedef struct packed {
    logic [7:0] b;
    logic       has_rec;
    rec_t       rec;
  } dir_row_t;

  localparam rec_t NO_REC = '0;

  localparam dir_row_t DIR_TAB [DIR_N] = '{
    // plain opcode extremes, invalid subcode, bad variable argument
    {8'h01, 1'b1, 16'd0, KIND_PLAIN, 7'd1, VC_NONE, 5'd0, 8'd0, 32'd0, 1'b0, 8'd0, 8'd1},
    {8'h7F, 1'b1, 16'd1, KIND_PLAIN, 7'd127, VC_NONE, 5'd0, 8'd0, 32'd0, 1'b0, 8'd0, 8'd1},
    {8'hFF, 1'b1, 16'd2, KIND_INVALID, 7'd31, VC_NONE, 5'd0, 8'd0, 32'd0, 1'b0, 8'd0, 8'd1},
    {8'h00, 1'b0, NO_REC},
    {8'h00, 1'b1, 16'd3, KIND_VAR_OP, 7'd0, VC_NONE, 5'd0, 8'd0, 32'd0, 1'b1, 8'd0, 8'd2},
    // constant pushes without immediate bytes
    {8'hE2, 1'b1, 16'd5, KIND_PUSH_CST, 7'd2, VC_NONE, 5'd0, 8'd0, FLOAT_ONE, 1'b0, 8'd0, 8'd1},
    {8'hE1, 1'b1, 16'd6, KIND_PUSH_CST, 7'd1, VC_NONE, 5'd0, 8'd0, 32'd1, 1'b0, 8'd0, 8'd1},
    {8'hE0, 1'b1, 16'd7, KIND_PUSH_CST, 7'd0, VC_NONE, 5'd0, 8'd0, 32'd0, 1'b0, 8'd0, 8'd1},
    {8'hE7, 1'b1, 16'd8, KIND_PUSH_CST, 7'd7, VC_NONE, 5'd0, 8'd0, 32'd0, 1'b0, 8'd0, 8'd1},
    // variable-argument opcodes: int, property, float, two bad references
    {8'h05, 1'b0, NO_REC}, {8'h9F, 1'b0, NO_REC},
    {8'h06, 1'b0, NO_REC}, {8'hA3, 1'b0, NO_REC}, {8'hFF, 1'b0, NO_REC},
    {8'h20, 1'b0, NO_REC}, {8'hDF, 1'b0, NO_REC},
    {8'h25, 1'b0, NO_REC}, {8'h7F, 1'b0, NO_REC},
    {8'h26, 1'b0, NO_REC}, {8'hE0, 1'b0, NO_REC},
    // jumps: one to the highest address, one to address 1
    {8'h43, 1'b0, NO_REC}, {8'hFF, 1'b0, NO_REC}, {8'hFF, 1'b0, NO_REC},
    {8'h44, 1'b0, NO_REC}, {8'h00, 1'b0, NO_REC}, {8'h01, 1'b0, NO_REC},
    // direct pushes
    {8'h80, 1'b0, NO_REC}, {8'hBF, 1'b0, NO_REC}, {8'h00, 1'b0, NO_REC},
    {8'hC0, 1'b0, NO_REC},
    // extended pushes with immediates, then an invalid subcode
    {8'hE3, 1'b0, NO_REC}, {8'hAA, 1'b0, NO_REC},
    {8'hE4, 1'b0, NO_REC}, {8'h12, 1'b0, NO_REC}, {8'h34, 1'b0, NO_REC},
    {8'hE5, 1'b0, NO_REC}, {8'hDE, 1'b0, NO_REC}, {8'hAD, 1'b0, NO_REC},
    {8'hBE, 1'b0, NO_REC}, {8'hEF, 1'b0, NO_REC},
    {8'hEA, 1'b0, NO_REC},
    // call: 16 header bytes, one name byte, terminator
    {8'h40, 1'b0, NO_REC},
    {8'h12, 1'b0, NO_REC}, {8'h34, 1'b0, NO_REC}, {8'h56, 1'b0, NO_REC},
    {8'h78, 1'b0, NO_REC},
    {8'hFF, 1'b0, NO_REC}, {8'hFF, 1'b0, NO_REC}, {8'hFF, 1'b0, NO_REC},
    {8'hFF, 1'b0, NO_REC}, {8'hFF, 1'b0, NO_REC}, {8'hFF, 1'b0, NO_REC},
    {8'hFF, 1'b0, NO_REC}, {8'hFF, 1'b0, NO_REC}, {8'hFF, 1'b0, NO_REC},
    {8'hFF, 1'b0, NO_REC}, {8'hFF, 1'b0, NO_REC}, {8'hFF, 1'b0, NO_REC},
    {8'h41, 1'b0, NO_REC}, {8'h00, 1'b0, NO_REC}
  };

  localparam logic [6:0] SPECIAL_OPS [9] = '{
    OP_VAR_A, OP_VAR_B, OP_VAR_C, OP_VAR_D, OP_VAR_E, OP_VAR_F,
    OP_CALL, OP_JUMP_A, OP_JUMP_B
  };

  // DUT signals
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = 16'd0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  code_byte_i = 8'd0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [15:0] start_offset_o;
  logic [3:0]  kind_o;
  logic [6:0]  code_o;
  logic [1:0]  var_class_o;
  logic [4:0]  var_num_o;
  logic [7:0]  prop_byte_o;
  logic [31:0] value_o;
  logic        arg_error_o;
  logic [7:0]  name_length_o;
  logic [7:0]  instr_length_o;

  // Local decoder state
  phase_e      m_phase = PH_OPCODE;
  kind_e       m_kind  = KIND_PLAIN;
  logic [4:0]  m_left  = '0;
  logic [31:0] m_acc   = '0;
  logic [15:0] m_ofs   = '0;
  logic [15:0] m_start = '0;
  logic [6:0]  m_code  = '0;
  logic [7:0]  m_var   = '0;
  logic [7:0]  m_len   = '0;
  logic [7:0]  m_nlen  = '0;

  rec_t decoded_q [$];
  int   fail_cnt   = 0;
  int   bytes_sent = 0;
  int   tx_gap     = 0;
  int   rx_wait    = 0;
  bit   tx_calm    = 1'b0;
  bit   rx_calm    = 1'b0;

  stack_bytecode_instruction_decoder uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .code_byte_i    (code_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .start_offset_o (start_offset_o),
    .kind_o         (kind_o),
    .code_o         (code_o),
    .var_class_o    (var_class_o),
    .var_num_o      (var_num_o),
    .prop_byte_o    (prop_byte_o),
    .value_o        (value_o),
    .arg_error_o    (arg_error_o),
    .name_length_o  (name_length_o),
    .instr_length_o (instr_length_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Reference byte class: top bit set, then bits 6:5 give int/prop/float
  function automatic varcls_e class_of(input logic [7:0] b);
    if (!b[7] || b[6:5] == 2'b11) return VC_NONE;
    return varcls_e'(b[6:5] + 2'd1);
  endfunction

  // Random wait, zero during calm stretches
  function automatic int draw_wait(input bit calm);
    if (calm) return 0;
    return $urandom_range(0, 13);
  endfunction

  // Close the current instruction and queue its record
  task automatic close_instr(input varcls_e cls, input logic [7:0] ref_b,
                             input logic [7:0] prop, input logic err);
    rec_t r;
    r.start_offset = m_start;
    r.kind         = m_kind;
    r.code         = m_code;
    r.var_class    = cls;
    r.var_num      = (cls == VC_NONE) ? 5'd0 : (ref_b[4:0] & VAR_IDX_MASK);
    r.prop_byte    = prop;
    r.value        = m_acc;
    r.arg_error    = err;
    r.name_length  = m_nlen;
    r.instr_length = m_len;
    decoded_q.push_back(r);
    m_phase = PH_OPCODE;
  endtask

  // Advance the local decoder by one accepted code byte
  task automatic decode_byte(input logic [7:0] b);
    logic [15:0] pos;
    varcls_e     cls;
    pos   = m_ofs;
    m_ofs = m_ofs + 16'd1;
    if (m_phase != PH_OPCODE && m_len != 8'hFF) m_len = m_len + 8'd1;
    case (m_phase)
      PH_ARG: begin
        m_var = b;
        cls = class_of(b);
        if (cls == VC_PROP) m_phase = PH_PROP;
        else if (cls == VC_NONE) close_instr(VC_NONE, 8'd0, 8'd0, 1'b1);
        else close_instr(cls, b, 8'd0, 1'b0);
      end
      PH_PROP: close_instr(VC_PROP, m_var, b, 1'b0);
      PH_IMM: begin
        m_acc = {m_acc[23:0], b};
        if (m_left != 5'd0) m_left = m_left - 5'd1;
        if (m_left == 5'd0) close_instr(VC_NONE, 8'd0, 8'd0, 1'b0);
      end
      PH_HDR: begin
        // only the first header word is kept
        if (m_left > CALL_WORD_LAST) m_acc = {m_acc[23:0], b};
        if (m_left != 5'd0) m_left = m_left - 5'd1;
        if (m_left == 5'd0) m_phase = PH_NAME;
      end
      PH_NAME: begin
        if (b == 8'd0) close_instr(VC_NONE, 8'd0, 8'd0, 1'b0);
        else if (m_nlen != 8'hFF) m_nlen = m_nlen + 8'd1;
      end
      default: begin
        // new instruction
        m_phase = PH_OPCODE;
        m_start = pos;
        m_len   = 8'd1;
        m_nlen  = 8'd0;
        m_acc   = 32'd0;
        m_var   = 8'd0;
        m_left  = 5'd0;
        if (!b[7]) begin
          m_code = b[6:0];
          case (b[6:0])
            OP_VAR_A, OP_VAR_B, OP_VAR_C, OP_VAR_D, OP_VAR_E, OP_VAR_F: begin
              m_kind  = KIND_VAR_OP;
              m_phase = PH_ARG;
            end
            OP_CALL: begin
              m_kind  = KIND_CALL;
              m_left  = CALL_HDR_BYTES;
              m_phase = PH_HDR;
            end
            OP_JUMP_A, OP_JUMP_B: begin
              m_kind  = KIND_JUMP;
              m_left  = 5'd2;
              m_phase = PH_IMM;
            end
            default: begin
              m_kind = KIND_PLAIN;
              close_instr(VC_NONE, 8'd0, 8'd0, 1'b0);
            end
          endcase
        end else begin
          cls = class_of(b);
          m_code = 7'd0;
          case (cls)
            VC_INT: begin
              m_kind = KIND_PUSH_INT;
              close_instr(VC_INT, b, 8'd0, 1'b0);
            end
            VC_FLOAT: begin
              m_kind = KIND_PUSH_FLT;
              close_instr(VC_FLOAT, b, 8'd0, 1'b0);
            end
            VC_PROP: begin
              m_kind  = KIND_PUSH_PROP;
              m_var   = b;
              m_phase = PH_PROP;
            end
            default: begin
              // extended push, subcode in the low five bits
              m_code = {2'b00, b[4:0]};
              m_kind = KIND_PUSH_CST;
              case (b[4:0])
                XP_ZERO, XP_NONE: close_instr(VC_NONE, 8'd0, 8'd0, 1'b0);
                XP_ONE: begin
                  m_acc = 32'd1;
                  close_instr(VC_NONE, 8'd0, 8'd0, 1'b0);
                end
                XP_FONE: begin
                  m_acc = FLOAT_ONE;
                  close_instr(VC_NONE, 8'd0, 8'd0, 1'b0);
                end
                XP_IMM8: begin
                  m_left  = 5'd1;
                  m_phase = PH_IMM;
                end
                XP_IMM16: begin
                  m_left  = 5'd2;
                  m_phase = PH_IMM;
                end
                XP_IMM32_A, XP_IMM32_B, XP_IMM32_C, XP_IMM32_D: begin
                  m_left  = 5'd4;
                  m_phase = PH_IMM;
                end
                default: begin
                  m_kind = KIND_INVALID;
                  close_instr(VC_NONE, 8'd0, 8'd0, 1'b0);
                end
              endcase
            end
          endcase
        end
      end
    endcase
  endtask

  task automatic cmp_field(input string name, input logic [31:0] want,
                           input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      fail_cnt++;
    end
  endtask

  task automatic check_record(input rec_t got);
    rec_t want;
    if (decoded_q.size() == 0) begin
      $error("unexpected record at start_offset 'h%0h", got.start_offset);
      fail_cnt++;
    end else begin
      want = decoded_q.pop_front();
      cmp_field("start_offset", 32'(want.start_offset), 32'(got.start_offset));
      cmp_field("kind", 32'(want.kind), 32'(got.kind));
      cmp_field("code", 32'(want.code), 32'(got.code));
      cmp_field("var_class", 32'(want.var_class), 32'(got.var_class));
      cmp_field("var_num", 32'(want.var_num), 32'(got.var_num));
      cmp_field("prop_byte", 32'(want.prop_byte), 32'(got.prop_byte));
      cmp_field("value", want.value, got.value);
      cmp_field("arg_error", 32'(want.arg_error), 32'(got.arg_error));
      cmp_field("name_length", 32'(want.name_length), 32'(got.name_length));
      cmp_field("instr_length", 32'(want.instr_length), 32'(got.instr_length));
    end
  endtask

  // Result side: random stall after each accepted record
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        check_record({start_offset_o, kind_o, code_o, var_class_o, var_num_o,
                      prop_byte_o, value_o, arg_error_o, name_length_o,
                      instr_length_o});
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        rx_wait = draw_wait(rx_calm);
        if (rx_wait != 0) out_ready_i <= 1'b0;
      end else if (!out_ready_i) begin
        if (rx_wait <= 1) out_ready_i <= 1'b1;
        else rx_wait = rx_wait - 1;
      end
    end
  end

  // One request on the byte channel; valid stays up when no gap follows
  task automatic send_byte(input logic [7:0] b);
    if (tx_gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (tx_gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    code_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    decode_byte(b);
    bytes_sent++;
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    tx_gap = draw_wait(tx_calm);
  endtask

  // Wait until every record is in, then let the pipe settle
  task automatic drain();
    in_valid_i <= 1'b0;
    tx_gap = 0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_offset(input logic [15:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    m_ofs = v;
  endtask

  // Supply mostly well-formed operands until the instruction closes, rarely cut short
  task automatic finish_instr();
    int         name_left;
    logic [7:0] b;
    name_left = -1;
    while (m_phase != PH_OPCODE) begin
      if ($urandom_range(0, 29) == 0) break;
      case (m_phase)
        PH_ARG: begin
          if ($urandom_range(0, 5) == 0) b = 8'($urandom_range(0, 255));
          else b = 8'($urandom_range(8'h80, 8'hDF));
        end
        PH_NAME: begin
          if (name_left < 0)
            name_left = ($urandom_range(0, 5) == 0) ? $urandom_range(250, 300)
                                                    : $urandom_range(0, 8);
          if (name_left == 0) begin
            b = 8'd0;
          end else begin
            b = 8'($urandom_range(1, 255));
            name_left--;
          end
        end
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_byte(b);
    end
  endtask

  task automatic run_random(input int target);
    int         sel;
    logic [7:0] b;
    while (bytes_sent < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        // stray byte, left unfinished
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        if (sel < 35) b = 8'($urandom_range(0, 127));
        else if (sel < 60) b = {1'b0, SPECIAL_OPS[$urandom_range(0, 8)]};
        else if (sel < 80) b = 8'($urandom_range(8'h80, 8'hDF));
        else if ($urandom_range(0, 3) == 0) b = {3'b111, 5'($urandom_range(0, 31))};
        else b = {3'b111, 5'($urandom_range(0, 9))};
        send_byte(b);
        finish_instr();
      end
    end
  endtask

  // Main sequence
  initial begin
    logic [15:0] offs [4];
    offs[0] = 16'hFFFF;
    offs[1] = 16'($urandom_range(0, 65535));
    offs[2] = 16'hFFF8;
    offs[3] = 16'($urandom_range(0, 65535));
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_offset(16'd0);

    // directed table
    for (int i = 0; i < DIR_N; i++) begin
      send_byte(DIR_TAB[i].b);
      if (DIR_TAB[i].has_rec) decoded_q[decoded_q.size() - 1] = DIR_TAB[i].rec;
    end

    // random phases, each from a new start offset
    for (int p = 0; p < 4; p++) begin
      drain();
      write_offset(offs[p]);
      run_random(bytes_sent + RAND_PER_PHASE);
    end
    drain();

    if (fail_cnt == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
